[rtl/bpa_pkg.sv]
package bpa_pkg;

   localparam int NUM_PAGES  = 4096;
   localparam int PAGE_SHIFT = 12;

   // page map is kept as words of WORD_W pages
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   // page bounds and free count must hold NUM_PAGES itself
   localparam int PG_W  = $clog2(NUM_PAGES + 1);
   localparam int CNT_W = PG_W;

   localparam int CMD_W  = 3;
   localparam int STAT_W = 3;
   localparam int ADDR_W = 32;
   localparam int LEN_W  = 33;
   localparam int TOP_W  = 34;
   localparam int RND_W  = 35;
   localparam int USE_W  = 40;
   localparam int UPG_W  = 28;
   localparam int FPC_W  = 13;

   localparam logic [RND_W-1:0] PG_MASK = RND_W'((64'd1 << PAGE_SHIFT) - 64'd1);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC          = 3'd0,
      CMD_FREE_PAGE      = 3'd1,
      CMD_FREE_REGION    = 3'd2,
      CMD_RESERVE_REGION = 3'd3,
      CMD_RESERVE_ALL    = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_OOM       = 3'd1,
      STAT_UNALIGNED = 3'd2,
      STAT_RANGE     = 3'd3,
      STAT_NOTALLOC  = 3'd4
   } status_type;

   typedef struct packed {
      logic              en;
      logic [WIDX_W-1:0] idx;
      logic [WORD_W-1:0] data;
   } map_wr_type;

endpackage

[rtl/bpa_map_ram.sv]
module bpa_map_ram (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [bpa_pkg::WIDX_W-1:0]  rd_idx,
   output logic [bpa_pkg::WORD_W-1:0]  rd_data,
   input  bpa_pkg::map_wr_type         wr
);
   import bpa_pkg::*;

   logic [WORD_W-1:0] mem [NUM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bitmap_page_allocator_unit.sv]
// channel  | handshake             | payload                                               | dir
// ---------+-----------------------+-------------------------------------------------------+----
// request  | req_valid / req_ready | cmd address length                                    | in
// response | rsp_valid / rsp_ready | page_address status free_page_count usable_page_count | out
//
// one transaction at a time, from the accepting edge to rsp_valid: a setup state, then
// the map words (32 pages each) are read in order and each is updated when its ram read returns,
// then a post state. allocate reads words up to the first free page, region commands the words
// touched, reserve everything writes all NUM_WORDS words; commands that touch no word skip the walk.
// after reset the same fill sweep runs with req_ready low.
// a waiting response does not block the next request; it stalls only the posting of the next response.
module bitmap_page_allocator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bpa_pkg::CMD_W-1:0]   req_cmd,
   input  logic [bpa_pkg::ADDR_W-1:0]  req_address,
   input  logic [bpa_pkg::LEN_W-1:0]   req_length,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bpa_pkg::ADDR_W-1:0]  rsp_page_address,
   output logic [bpa_pkg::STAT_W-1:0]  rsp_status,
   output logic [bpa_pkg::FPC_W-1:0]   rsp_free_page_count,
   output logic [bpa_pkg::UPG_W-1:0]   rsp_usable_page_count
);
   import bpa_pkg::*;

   typedef enum logic [2:0] {
      S_FILL, S_IDLE, S_SETUP, S_WALK, S_SCAN, S_DONE
   } state_type;

   function automatic logic [PG_W-1:0] clamp_page(input logic [RND_W-1:0] v);
      if (v > RND_W'(NUM_PAGES)) begin
         return PG_W'(NUM_PAGES);
      end
      return PG_W'(v);
   endfunction

   function automatic logic [BIT_W:0] popcount(input logic [WORD_W-1:0] v);
      logic [2:0]     nib [WORD_W/4];
      logic [BIT_W:0] s;
      s = '0;
      for (int i = 0; i < WORD_W / 4; i++) begin
         nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
      end
      for (int i = 0; i < WORD_W / 4; i++) begin
         s = s + (BIT_W+1)'(nib[i]);
      end
      return s;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] inv;
      logic [WORD_W-1:0] one;
      logic [BIT_W-1:0]  z;
      inv = ~v;
      one = inv & (~inv + WORD_W'(1));
      z = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (one[i]) begin
            z = z | BIT_W'(i);
         end
      end
      return z;
   endfunction

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [PG_W-1:0]   lo_ff, lo_in;
   logic [PG_W-1:0]   hi_ff, hi_in;
   logic              set_ff, set_in;
   logic              fill_rsp_ff, fill_rsp_in;
   logic [WIDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic              rd_on_ff, rd_on_in;
   logic [WIDX_W-1:0] last_w_ff, last_w_in;
   logic              p_valid_ff, p_valid_in;
   logic [WIDX_W-1:0] p_idx_ff, p_idx_in;
   logic [CNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [USE_W-1:0]  usable_ff, usable_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] page_addr_ff, page_addr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_page_address_ff, rsp_page_address_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FPC_W-1:0]  rsp_free_page_count_ff, rsp_free_page_count_in;
   logic [UPG_W-1:0]  rsp_usable_page_count_ff, rsp_usable_page_count_in;

   // map ram
   logic              ram_rd_en;
   logic [WORD_W-1:0] ram_q;
   map_wr_type        ram_wr;

   // setup terms
   logic [RND_W-1:0]  free_start;
   logic              free_nonempty;
   logic [PG_W-1:0]   fr_lo, fr_hi, rr_lo, rr_hi, fp_lo, fp_hi;
   logic              fp_unaligned, fp_range;
   logic [USE_W:0]    usable_sum;

   // word update terms
   logic [PG_W-1:0]   hm1;
   logic [WORD_W-1:0] mask_lo, mask_hi, mask, new_word, changed;
   logic [BIT_W:0]    change_cnt;
   logic [BIT_W-1:0]  zero_bit;
   logic [USE_W-1:0]  usable_pages;

   bpa_map_ram u_map_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_idx  (rd_idx_ff),
      .rd_data (ram_q),
      .wr      (ram_wr)
   );

   assign free_start    = (RND_W'(addr_ff) + PG_MASK) & ~PG_MASK;
   assign free_nonempty = free_start < RND_W'(top_ff);
   assign fr_lo         = clamp_page(free_start >> PAGE_SHIFT);
   assign fr_hi         = clamp_page(RND_W'(top_ff) >> PAGE_SHIFT);
   assign rr_lo         = clamp_page(RND_W'(addr_ff) >> PAGE_SHIFT);
   assign rr_hi         = clamp_page((RND_W'(top_ff) + PG_MASK) >> PAGE_SHIFT);
   assign fp_unaligned  = (RND_W'(addr_ff) & PG_MASK) != '0;
   assign fp_range      = (RND_W'(addr_ff) >> PAGE_SHIFT) >= RND_W'(NUM_PAGES);
   assign fp_lo         = PG_W'(RND_W'(addr_ff) >> PAGE_SHIFT);
   assign fp_hi         = fp_lo + PG_W'(1);
   assign usable_sum    = (USE_W+1)'(usable_ff) + (USE_W+1)'(len_ff);

   // bits of the word in stage two that fall inside [lo, hi)
   assign hm1      = hi_ff - PG_W'(1);
   assign mask_lo  = (p_idx_ff == WIDX_W'(lo_ff >> BIT_W)) ? ('1 << BIT_W'(lo_ff)) : '1;
   assign mask_hi  = (p_idx_ff == WIDX_W'(hm1 >> BIT_W)) ? ('1 >> (~BIT_W'(hm1))) : '1;
   assign mask     = mask_lo & mask_hi;
   assign new_word = set_ff ? (ram_q | mask) : (ram_q & ~mask);
   assign changed  = new_word ^ ram_q;
   assign change_cnt = popcount(changed);
   assign zero_bit   = lowest_zero(ram_q);
   assign usable_pages = usable_ff >> PAGE_SHIFT;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      top_in       = top_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      set_in       = set_ff;
      fill_rsp_in  = fill_rsp_ff;
      rd_idx_in    = rd_idx_ff;
      rd_on_in     = rd_on_ff;
      last_w_in    = last_w_ff;
      p_valid_in   = 1'b0;
      p_idx_in     = p_idx_ff;
      free_cnt_in  = free_cnt_ff;
      usable_in    = usable_ff;
      status_in    = status_ff;
      page_addr_in = page_addr_ff;

      rsp_valid_in             = rsp_valid_ff & ~rsp_ready;
      rsp_page_address_in      = rsp_page_address_ff;
      rsp_status_in            = rsp_status_ff;
      rsp_free_page_count_in   = rsp_free_page_count_ff;
      rsp_usable_page_count_in = rsp_usable_page_count_ff;

      ram_rd_en   = 1'b0;
      ram_wr.en   = 1'b0;
      ram_wr.idx  = p_idx_ff;
      ram_wr.data = new_word;

      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_FILL: begin
            ram_wr.en   = 1'b1;
            ram_wr.idx  = rd_idx_ff;
            ram_wr.data = '1;
            if (rd_idx_ff == WIDX_W'(NUM_WORDS - 1)) begin
               state_in = fill_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + WIDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               addr_in  = req_address;
               len_in   = req_length;
               top_in   = TOP_W'(req_address) + TOP_W'(req_length);
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            status_in    = STAT_OK;
            page_addr_in = '0;
            set_in       = 1'b0;
            state_in     = S_DONE;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (free_cnt_ff == '0) begin
                     status_in = STAT_OOM;
                  end else begin
                     rd_idx_in = '0;
                     rd_on_in  = 1'b1;
                     last_w_in = WIDX_W'(NUM_WORDS - 1);
                     state_in  = S_SCAN;
                  end
               end
               CMD_FREE_PAGE: begin
                  if (fp_unaligned) begin
                     status_in = STAT_UNALIGNED;
                  end else if (fp_range) begin
                     status_in = STAT_RANGE;
                  end else begin
                     lo_in     = fp_lo;
                     hi_in     = fp_hi;
                     rd_idx_in = WIDX_W'(fp_lo >> BIT_W);
                     last_w_in = WIDX_W'(fp_lo >> BIT_W);
                     rd_on_in  = 1'b1;
                     state_in  = S_WALK;
                  end
               end
               CMD_FREE_REGION: begin
                  usable_in = usable_sum[USE_W] ? '1 : usable_sum[USE_W-1:0];
                  if (free_nonempty && (fr_lo < fr_hi)) begin
                     lo_in     = fr_lo;
                     hi_in     = fr_hi;
                     rd_idx_in = WIDX_W'(fr_lo >> BIT_W);
                     last_w_in = WIDX_W'((fr_hi - PG_W'(1)) >> BIT_W);
                     rd_on_in  = 1'b1;
                     state_in  = S_WALK;
                  end
               end
               CMD_RESERVE_REGION: begin
                  set_in = 1'b1;
                  if (rr_lo < rr_hi) begin
                     lo_in     = rr_lo;
                     hi_in     = rr_hi;
                     rd_idx_in = WIDX_W'(rr_lo >> BIT_W);
                     last_w_in = WIDX_W'((rr_hi - PG_W'(1)) >> BIT_W);
                     rd_on_in  = 1'b1;
                     state_in  = S_WALK;
                  end
               end
               CMD_RESERVE_ALL: begin
                  usable_in   = '0;
                  free_cnt_in = '0;
                  rd_idx_in   = '0;
                  fill_rsp_in = 1'b1;
                  state_in    = S_FILL;
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end
         S_WALK, S_SCAN: begin
            // read one word ahead of the one being modified
            if (rd_on_ff) begin
               ram_rd_en  = 1'b1;
               p_valid_in = 1'b1;
               p_idx_in   = rd_idx_ff;
               if (rd_idx_ff == last_w_ff) begin
                  rd_on_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + WIDX_W'(1);
               end
            end
            if (p_valid_ff) begin
               if (state_ff == S_WALK) begin
                  ram_wr.en = 1'b1;
                  if (set_ff) begin
                     free_cnt_in = free_cnt_ff - CNT_W'(change_cnt);
                  end else begin
                     free_cnt_in = free_cnt_ff + CNT_W'(change_cnt);
                  end
                  if ((cmd_ff == CMD_FREE_PAGE) && !ram_q[BIT_W'(lo_ff)]) begin
                     status_in = STAT_NOTALLOC;
                  end
                  if (p_idx_ff == last_w_ff) begin
                     state_in = S_DONE;
                  end
               end else if (ram_q != '1) begin
                  ram_wr.en    = 1'b1;
                  ram_wr.data  = ram_q | (WORD_W'(1) << zero_bit);
                  free_cnt_in  = free_cnt_ff - CNT_W'(1);
                  page_addr_in = ADDR_W'(64'({p_idx_ff, zero_bit}) << PAGE_SHIFT);
                  rd_on_in     = 1'b0;
                  p_valid_in   = 1'b0;
                  state_in     = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_page_address_in    = page_addr_ff;
               rsp_status_in          = status_ff;
               rsp_free_page_count_in = FPC_W'(free_cnt_ff);
               if (usable_pages > USE_W'({UPG_W{1'b1}})) begin
                  rsp_usable_page_count_in = '1;
               end else begin
                  rsp_usable_page_count_in = UPG_W'(usable_pages);
               end
               fill_rsp_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         fill_rsp_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         rd_on_ff     <= 1'b0;
         p_valid_ff   <= 1'b0;
         free_cnt_ff  <= '0;
         usable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_rsp_ff  <= fill_rsp_in;
         rd_idx_ff    <= rd_idx_in;
         rd_on_ff     <= rd_on_in;
         p_valid_ff   <= p_valid_in;
         free_cnt_ff  <= free_cnt_in;
         usable_ff    <= usable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff                   <= cmd_in;
      addr_ff                  <= addr_in;
      len_ff                   <= len_in;
      top_ff                   <= top_in;
      lo_ff                    <= lo_in;
      hi_ff                    <= hi_in;
      set_ff                   <= set_in;
      last_w_ff                <= last_w_in;
      p_idx_ff                 <= p_idx_in;
      status_ff                <= status_in;
      page_addr_ff             <= page_addr_in;
      rsp_page_address_ff      <= rsp_page_address_in;
      rsp_status_ff            <= rsp_status_in;
      rsp_free_page_count_ff   <= rsp_free_page_count_in;
      rsp_usable_page_count_ff <= rsp_usable_page_count_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_page_address      = rsp_page_address_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_free_page_count   = rsp_free_page_count_ff;
   assign rsp_usable_page_count = rsp_usable_page_count_ff;

endmodule
